FILE: hdl/yuvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package yuvc_pkg;

  // Chroma products are at most about 15 million in magnitude.
  localparam int TERM_W = 26;
  // Luma term plus chroma term, signed.
  localparam int SUM_W  = 28;

  localparam logic color_mode_studio = 1'b0;
  localparam logic color_mode_full   = 1'b1;

  // Studio-range coefficients (Q8).
  localparam logic signed [TERM_W-1:0] StudioLuma    = TERM_W'(298);
  localparam logic signed [TERM_W-1:0] StudioBlueU   = TERM_W'(516);
  localparam logic signed [TERM_W-1:0] StudioGreenU  = -TERM_W'(100);
  localparam logic signed [TERM_W-1:0] StudioGreenV  = -TERM_W'(208);
  localparam logic signed [TERM_W-1:0] StudioRedV    = TERM_W'(409);
  localparam logic signed [SUM_W-1:0]  StudioRound   = SUM_W'(128);
  localparam logic signed [8:0]        StudioBlack   = 9'sd16;

  // Full-range coefficients (Q16).
  localparam logic signed [TERM_W-1:0] FullRedV      = TERM_W'(91881);
  localparam logic signed [TERM_W-1:0] FullGreenU    = -TERM_W'(22554);
  localparam logic signed [TERM_W-1:0] FullGreenV    = -TERM_W'(46802);
  localparam logic signed [TERM_W-1:0] FullBlueU     = TERM_W'(116130);

  localparam logic signed [8:0]        ChromaZero    = 9'sd128;

  typedef struct packed {
    logic                     mode;
    logic signed [TERM_W-1:0] red_term;
    logic signed [TERM_W-1:0] green_term;
    logic signed [TERM_W-1:0] blue_term;
  } chroma_terms_t;

  // Saturate a signed channel value to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > SUM_W'(255)) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/yuvc_chroma.sv
`timescale 1ns / 1ps
`default_nettype none
module yuvc_chroma (
  input  wire logic                   clk,
  input  wire logic                   mode,
  input  wire logic [7:0]             chroma_blue,
  input  wire logic [7:0]             chroma_red,
  output yuvc_pkg::chroma_terms_t     terms
);
  import yuvc_pkg::*;

  logic signed [8:0]        d;
  logic signed [8:0]        e;
  logic signed [TERM_W-1:0] d_w;
  logic signed [TERM_W-1:0] e_w;
  chroma_terms_t            terms_nxt;
  chroma_terms_t            terms_r;

  assign d   = signed'({1'b0, chroma_blue}) - ChromaZero;
  assign e   = signed'({1'b0, chroma_red}) - ChromaZero;
  assign d_w = TERM_W'(d);
  assign e_w = TERM_W'(e);

  // The chroma products are shared by both pixels of the pair.
  always_comb begin
    terms_nxt.mode = mode;
    if (mode == color_mode_full) begin
      terms_nxt.red_term   = e_w * FullRedV;
      terms_nxt.green_term = d_w * FullGreenU + e_w * FullGreenV;
      terms_nxt.blue_term  = d_w * FullBlueU;
    end else begin
      terms_nxt.red_term   = e_w * StudioRedV;
      terms_nxt.green_term = d_w * StudioGreenU + e_w * StudioGreenV;
      terms_nxt.blue_term  = d_w * StudioBlueU;
    end
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
  end

  assign terms = terms_r;

endmodule
`default_nettype wire

FILE: hdl/yuvc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module yuvc_lane (
  input  wire logic                   clk,
  input  wire logic                   mode,
  input  wire logic [7:0]             luma,
  input  wire yuvc_pkg::chroma_terms_t terms,
  output logic [23:0]                 pixel
);
  import yuvc_pkg::*;

  logic signed [8:0]       c;
  logic signed [SUM_W-1:0] luma_nxt;
  logic signed [SUM_W-1:0] luma_r;
  logic signed [SUM_W-1:0] sum_r_ch;
  logic signed [SUM_W-1:0] sum_g_ch;
  logic signed [SUM_W-1:0] sum_b_ch;
  logic signed [SUM_W-1:0] sh_r;
  logic signed [SUM_W-1:0] sh_g;
  logic signed [SUM_W-1:0] sh_b;

  assign c = signed'({1'b0, luma}) - StudioBlack;

  // Full range folds Y into the Q16 sum so both modes end in one shift.
  always_comb begin
    if (mode == color_mode_full) begin
      luma_nxt = signed'(SUM_W'({luma, 16'd0}));
    end else begin
      luma_nxt = SUM_W'(TERM_W'(c) * StudioLuma) + StudioRound;
    end
  end

  always_ff @(posedge clk) begin
    luma_r <= luma_nxt;
  end

  assign sum_r_ch = luma_r + SUM_W'(terms.red_term);
  assign sum_g_ch = luma_r + SUM_W'(terms.green_term);
  assign sum_b_ch = luma_r + SUM_W'(terms.blue_term);

  always_comb begin
    if (terms.mode == color_mode_full) begin
      sh_r = sum_r_ch >>> 16;
      sh_g = sum_g_ch >>> 16;
      sh_b = sum_b_ch >>> 16;
    end else begin
      sh_r = sum_r_ch >>> 8;
      sh_g = sum_g_ch >>> 8;
      sh_b = sum_b_ch >>> 8;
    end
  end

  assign pixel = {clamp8(sh_r), clamp8(sh_g), clamp8(sh_b)};

endmodule
`default_nettype wire

FILE: hdl/yuv_pair_to_rgb32_converter.sv
// Channel  Ports                                            Handshake
// input    in_luma_first, in_luma_second, in_chroma_blue,   start and not busy
//          in_chroma_red
// result   out_pixel_first, out_pixel_second                out_valid, one cycle
// config   cfg_data (color_mode)                            cfg_valid and cfg_ready
//
// One pixel pair is accepted every cycle; its result passes through the registered
// multiplier stage and then the output register before it appears.
// busy stays low and cfg_ready stays high; the result side cannot stall.
// Synchronous reset clears the pipeline valid bits and sets color_mode to 0.
`timescale 1ns / 1ps
`default_nettype none
module yuv_pair_to_rgb32_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_luma_first,
  input  wire logic [7:0]  in_luma_second,
  input  wire logic [7:0]  in_chroma_blue,
  input  wire logic [7:0]  in_chroma_red,
  output logic             out_valid,
  output logic [23:0]      out_pixel_first,
  output logic [23:0]      out_pixel_second,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import yuvc_pkg::*;

  logic          color_mode_r;
  logic          accept;
  logic          s1_valid_r;
  logic          out_valid_r;
  logic [23:0]   pix_first;
  logic [23:0]   pix_second;
  logic [23:0]   pix_first_r;
  logic [23:0]   pix_second_r;
  chroma_terms_t terms;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= color_mode_studio;
    end else if (cfg_valid && cfg_ready) begin
      color_mode_r <= cfg_data;
    end
  end

  yuvc_chroma u_chroma (
    .clk         (clk),
    .mode        (color_mode_r),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .terms       (terms)
  );

  yuvc_lane u_lane_first (
    .clk   (clk),
    .mode  (color_mode_r),
    .luma  (in_luma_first),
    .terms (terms),
    .pixel (pix_first)
  );

  yuvc_lane u_lane_second (
    .clk   (clk),
    .mode  (color_mode_r),
    .luma  (in_luma_second),
    .terms (terms),
    .pixel (pix_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  // Both lanes land in the output register in the same beat.
  always_ff @(posedge clk) begin
    pix_first_r  <= pix_first;
    pix_second_r <= pix_second;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_first  = pix_first_r;
  assign out_pixel_second = pix_second_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##2 !out_valid)
    else $error("result without an accepted beat");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_luma_first == in_luma_second) |-> ##2
      (out_pixel_first == out_pixel_second))
    else $error("lanes disagree for equal luma");

endmodule
`default_nettype wire

FILE: tb/tb_yuv_pair_to_rgb32_converter.sv
`timescale 1ns / 1ps
module tb_yuv_pair_to_rgb32_converter;
  import yuvc_pkg::*;

  localparam int StallLimit = 1000;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuv_pair_t;

  typedef struct packed {
    logic [23:0] pixel_first;
    logic [23:0] pixel_second;
  } rgb_pair_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_luma_first;
  logic [7:0]  in_luma_second;
  logic [7:0]  in_chroma_blue;
  logic [7:0]  in_chroma_red;
  logic        out_valid;
  logic [23:0] out_pixel_first;
  logic [23:0] out_pixel_second;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  yuv_pair_t pending_pairs[$];
  rgb_pair_t expected_pixels[$];
  logic      color_mode_shadow;
  logic      gaps_on;
  logic      hold_sender;
  int        failures = 0;
  int        stall_cycles = 0;

  yuv_pair_to_rgb32_converter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_luma_first    (in_luma_first),
    .in_luma_second   (in_luma_second),
    .in_chroma_blue   (in_chroma_blue),
    .in_chroma_red    (in_chroma_red),
    .out_valid        (out_valid),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] saturate_channel(input int v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // Both formulas floor on the shift, so >>> on a signed int is exact here.
  function automatic logic [23:0] rgb_from_yuv(input logic mode, input logic [7:0] luma,
                                               input logic [7:0] u, input logic [7:0] v);
    int c;
    int d;
    int e;
    int r;
    int g;
    int b;
    d = int'(u) - 128;
    e = int'(v) - 128;
    if (mode == color_mode_full) begin
      r = int'(luma) + ((91881 * e) >>> 16);
      g = int'(luma) + ((-22554 * d - 46802 * e) >>> 16);
      b = int'(luma) + ((116130 * d) >>> 16);
    end else begin
      c = int'(luma) - 16;
      r = (298 * c + 409 * e + 128) >>> 8;
      g = (298 * c - 100 * d - 208 * e + 128) >>> 8;
      b = (298 * c + 516 * d + 128) >>> 8;
    end
    return {saturate_channel(r), saturate_channel(g), saturate_channel(b)};
  endfunction

  function automatic logic [7:0] random_sample();
    logic [7:0] res;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: res = 8'd0;
        1: res = 8'd255;
        2: res = 8'd16;
        3: res = 8'd235;
        default: res = 8'd128;
      endcase
    end else begin
      res = 8'($urandom_range(255));
    end
    return res;
  endfunction

  // Driver: a beat is accepted when start is high and busy is low.
  always @(posedge clk) begin
    yuv_pair_t nxt;
    rgb_pair_t predicted;
    logic      issue;
    if (!rst_n) begin
      start          <= 1'b0;
      in_luma_first  <= 8'd0;
      in_luma_second <= 8'd0;
      in_chroma_blue <= 8'd0;
      in_chroma_red  <= 8'd0;
    end else begin
      issue = start;
      if (start && !busy) begin
        predicted.pixel_first  = rgb_from_yuv(color_mode_shadow, in_luma_first,
                                              in_chroma_blue, in_chroma_red);
        predicted.pixel_second = rgb_from_yuv(color_mode_shadow, in_luma_second,
                                              in_chroma_blue, in_chroma_red);
        expected_pixels.insert(expected_pixels.size(), predicted);
        issue = 1'b0;
      end
      if (!issue) begin
        if (!hold_sender && pending_pairs.size() > 0 &&
            !(gaps_on && $urandom_range(99) < 21)) begin
          nxt = pending_pairs.pop_front();
          in_luma_first  <= nxt.luma_first;
          in_luma_second <= nxt.luma_second;
          in_chroma_blue <= nxt.chroma_blue;
          in_chroma_red  <= nxt.chroma_red;
          issue = 1'b1;
        end else begin
          // Noise on the fields while start is low must be ignored.
          in_luma_first  <= 8'($urandom);
          in_luma_second <= 8'($urandom);
          in_chroma_blue <= 8'($urandom);
          in_chroma_red  <= 8'($urandom);
        end
      end
      start <= issue;
    end
  end

  always @(posedge clk) begin
    rgb_pair_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat: out_pixel_first %06h, out_pixel_second %06h",
               out_pixel_first, out_pixel_second);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_first !== want.pixel_first) begin
          $error("out_pixel_first mismatch: expected %06h, actual %06h",
                 want.pixel_first, out_pixel_first);
          failures++;
        end
        if (out_pixel_second !== want.pixel_second) begin
          $error("out_pixel_second mismatch: expected %06h, actual %06h",
                 want.pixel_second, out_pixel_second);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_color_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    color_mode_shadow = mode;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_pairs.size() > 0 || start || expected_pixels.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic enqueue_pair(input logic [7:0] l0, input logic [7:0] l1,
                              input logic [7:0] u, input logic [7:0] v);
    yuv_pair_t p;
    p.luma_first  = l0;
    p.luma_second = l1;
    p.chroma_blue = u;
    p.chroma_red  = v;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic queue_directed();
    enqueue_pair(8'd0,   8'd255, 8'd0,   8'd0);
    enqueue_pair(8'd255, 8'd0,   8'd255, 8'd255);
    enqueue_pair(8'd16,  8'd235, 8'd128, 8'd128);
    enqueue_pair(8'd0,   8'd0,   8'd0,   8'd255);
    enqueue_pair(8'd255, 8'd255, 8'd255, 8'd0);
    enqueue_pair(8'd128, 8'd128, 8'd0,   8'd128);
    enqueue_pair(8'd128, 8'd128, 8'd255, 8'd128);
    enqueue_pair(8'd128, 8'd128, 8'd128, 8'd0);
    enqueue_pair(8'd128, 8'd128, 8'd128, 8'd255);
    enqueue_pair(8'h55,  8'haa,  8'h55,  8'haa);
    enqueue_pair(8'haa,  8'h55,  8'haa,  8'h55);
    enqueue_pair(8'd15,  8'd16,  8'd127, 8'd129);
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      enqueue_pair(random_sample(), random_sample(), random_sample(), random_sample());
    end
  endtask

  initial begin
    int settle;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_data          = 1'b0;
    color_mode_shadow = color_mode_studio;
    gaps_on           = 1'b0;
    hold_sender       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first pass relies on the reset value of the mode.
    queue_directed();
    wait_for_drain();
    write_color_mode(color_mode_full);
    queue_directed();
    wait_for_drain();

    gaps_on <= 1'b1;
    write_color_mode(color_mode_studio);
    queue_random(300);
    wait_for_drain();

    gaps_on <= 1'b0;
    write_color_mode(color_mode_full);
    queue_random(300);
    wait_for_drain();

    gaps_on <= 1'b1;
    write_color_mode(color_mode_studio);
    queue_random(400);
    while (pending_pairs.size() > 200) @(posedge clk);
    // Hold the sender mid-stream until the pipeline has emptied.
    hold_sender <= 1'b1;
    @(posedge clk);
    while (start || expected_pixels.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
    hold_sender <= 1'b0;
    wait_for_drain();

    write_color_mode(color_mode_full);
    queue_random(300);
    wait_for_drain();

    settle = 0;
    while (expected_pixels.size() > 0 && settle < 200) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d result beats never arrived", expected_pixels.size());
    end
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
